// ===== src/kmagg_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kmagg_pkg
// shared types, limits and saturating adders for the keyed record merge
// ---------------------------------------------------------------------------
package kmagg_pkg;

	typedef logic signed [63:0] key_t;
	typedef logic signed [31:0] count_t;
	typedef logic signed [47:0] cost_t;
	typedef logic [2:0] mode_t;

	typedef struct packed {
		key_t   key;
		count_t count;
		cost_t  cost;
		logic   primary;
		mode_t  mode;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic cmp;
		logic apply;
		logic ins;
		logic shift;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_EMIT
	} state_t;

	localparam count_t CNT_MAX  = 32'sh7FFF_FFFF;
	localparam count_t CNT_MIN  = 32'sh8000_0000;
	localparam cost_t  COST_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam cost_t  COST_MIN = 48'sh8000_0000_0000;

	function automatic count_t sat_add_count(input count_t a, input count_t b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? CNT_MIN : CNT_MAX;
		end
		return s[31:0];
	endfunction

	function automatic cost_t sat_add_cost(input cost_t a, input cost_t b);
		logic [48:0] s;
		s = {a[47], a} + {b[47], b};
		if (s[48] != s[47]) begin
			return s[48] ? COST_MIN : COST_MAX;
		end
		return s[47:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/keyed_record_merge_aggregate.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// keyed_record_merge_aggregate
// group-by merge of keyed records into a sorted chain of cells
// ---------------------------------------------------------------------------
// Records enter on the rec channel (rec_valid / rec_stall). Each beat is
// compared against every cell on the edge it is taken and merged or inserted
// on the next edge; rec_stall is high while the merge cycle and any emission
// are under way.
// A record with rec_last set is merged and then the whole table drains in
// ascending key order on the out channel (out_valid / out_stall): the first
// result is loaded into the output register in the emit state that follows
// the merge, then one result per cycle while the receiver does not stall. The
// cells shift toward slot 0 by one per beat; a stall holds the output
// register and the chain. out_last marks the final result, out_dropped
// tells whether a new key found the table full during that run.
// Reset (arst_n low) empties the table and clears the drop flag; cell
// contents are not cleared, the fill count marks which cells are live.
// ---------------------------------------------------------------------------
module keyed_record_merge_aggregate #(
	parameter int ENTRIES = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   rec_valid,
	output logic                  rec_stall,
	input  kmagg_pkg::key_t       rec_key,
	input  kmagg_pkg::count_t     rec_count,
	input  kmagg_pkg::cost_t      rec_cost,
	input  wire                   rec_primary,
	input  kmagg_pkg::mode_t      rec_mode,
	input  wire                   rec_last,
	output logic                  out_valid,
	input  wire                   out_stall,
	output kmagg_pkg::key_t       out_key,
	output kmagg_pkg::count_t     out_count,
	output kmagg_pkg::cost_t      out_cost,
	output logic                  out_primary,
	output kmagg_pkg::mode_t      out_mode,
	output logic                  out_last,
	output logic                  out_dropped
);
	import kmagg_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] used_q;
	logic             dropped_q;
	entry_t           rec_s1;
	logic             last_s1;
	cell_cmd_t        cmd;
	logic             accept;
	logic             emit_ld;
	logic             match_any;
	logic             full;
	logic             ins;

	entry_t           ent [ENTRIES];
	logic [ENTRIES-1:0] eq_vec;
	logic [ENTRIES-1:0] gt_vec;

	entry_t           out_q;
	logic             out_valid_q;
	logic             out_last_q;
	logic             out_dropped_q;

	assign accept    = rec_valid && !rec_stall;
	assign match_any = |eq_vec;
	assign full      = (used_q == CNT_W'(ENTRIES));
	assign ins       = !match_any && !full;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_MERGE;
			end
			ST_MERGE: begin
				state_d = last_s1 ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (used_q == '0 || (emit_ld && used_q == CNT_W'(1))) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		rec_stall = 1'b1;
		emit_ld   = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				rec_stall = 1'b0;
				cmd.cmp   = rec_valid;
			end
			ST_MERGE: begin
				cmd.apply = 1'b1;
				cmd.ins   = ins;
			end
			ST_EMIT: begin
				emit_ld   = (used_q != '0) && (!out_valid_q || !out_stall);
				cmd.shift = emit_ld;
			end
			default: begin
				rec_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MERGE) begin
				if (ins) used_q <= used_q + CNT_W'(1);
				if (!match_any && full) dropped_q <= 1'b1;
			end else if (emit_ld) begin
				used_q <= used_q - CNT_W'(1);
				if (used_q == CNT_W'(1)) dropped_q <= 1'b0;
			end
			if (emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1.key     <= rec_key;
			rec_s1.count   <= rec_count;
			rec_s1.cost    <= rec_cost;
			rec_s1.primary <= rec_primary;
			rec_s1.mode    <= rec_mode;
			last_s1        <= rec_last;
		end
		if (emit_ld) begin
			out_q         <= ent[0];
			out_last_q    <= (used_q == CNT_W'(1));
			out_dropped_q <= dropped_q;
		end
	end

	// chain of cells, slot 0 holds the smallest key
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kmagg_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (CNT_W'(i) < used_q),
			.cmp_key   (rec_key),
			.rec       (rec_s1),
			.left_ent  ((i == 0) ? ent[i] : ent[(i == 0) ? 0 : i - 1]),
			.left_gt   ((i == 0) ? 1'b0 : gt_vec[(i == 0) ? 0 : i - 1]),
			.right_ent (ent[(i == ENTRIES - 1) ? i : i + 1]),
			.ent       (ent[i]),
			.eq        (eq_vec[i]),
			.gt        (gt_vec[i])
		);
	end

	assign out_valid   = out_valid_q;
	assign out_key     = out_q.key;
	assign out_count   = out_q.count;
	assign out_cost    = out_q.cost;
	assign out_primary = out_q.primary;
	assign out_mode    = out_q.mode;
	assign out_last    = out_last_q;
	assign out_dropped = out_dropped_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(ENTRIES))
		else $error("fill count beyond table size");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> $onehot0(eq_vec))
		else $error("key held in more than one cell");

	a_accept_merge: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MERGE)
		else $error("accepted record not merged next cycle");

	a_final_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_ld && used_q == CNT_W'(1)) |=> (out_valid && out_last && used_q == '0))
		else $error("final result not marked");

endmodule
`default_nettype wire

// ===== src/kmagg_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kmagg_cell
// one slot of the sorted table: compares, merges, inserts and shifts
// ---------------------------------------------------------------------------
module kmagg_cell (
	input  wire                    clk,
	input  kmagg_pkg::cell_cmd_t   cmd,
	input  wire                    occ,
	input  kmagg_pkg::key_t        cmp_key,
	input  kmagg_pkg::entry_t      rec,
	input  kmagg_pkg::entry_t      left_ent,
	input  wire                    left_gt,
	input  kmagg_pkg::entry_t      right_ent,
	output kmagg_pkg::entry_t      ent,
	output logic                   eq,
	output logic                   gt
);
	import kmagg_pkg::*;

	entry_t ent_q;
	logic   eq_s1;
	logic   gt_s1;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			eq_s1 <= occ && (ent_q.key == cmp_key);
			gt_s1 <= !occ || (ent_q.key > cmp_key);
		end
		if (cmd.apply) begin
			if (eq_s1) begin
				ent_q.count   <= sat_add_count(ent_q.count, rec.count);
				ent_q.cost    <= sat_add_cost(ent_q.cost, rec.cost);
				ent_q.primary <= ent_q.primary & rec.primary;
				ent_q.mode    <= (rec.mode > ent_q.mode) ? rec.mode : ent_q.mode;
			end else if (cmd.ins && gt_s1) begin
				ent_q <= left_gt ? left_ent : rec;
			end
		end else if (cmd.shift) begin
			ent_q <= right_ent;
		end
	end

	assign ent = ent_q;
	assign eq  = eq_s1;
	assign gt  = gt_s1;

endmodule
`default_nettype wire
